/* src/lpd_pkg.sv */
// Shared types and constants for the length-prefix deframer.
`timescale 1ns / 1ps
package lpd_pkg;

    // Number of length bytes in one header, least significant byte first.
    localparam int LENGTH_BYTES_DEF = 4;

    // Widths fixed by the field definitions.
    localparam int BYTE_W    = 8;
    localparam int LENGTH_W  = 32;
    localparam int HCOUNT_W  = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_MAX_LENGTH = 1'b0;

    // Reset value of the largest accepted length.
    localparam logic [LENGTH_W-1:0] MAX_LENGTH_RST = '1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_REJECT  = 2'd3
    } t_kind;

    // Held input request passed from the input register to the core.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_req;

endpackage

/* src/lpd_regs.sv */
// APB-style configuration register for the largest accepted length.
`timescale 1ns / 1ps
module lpd_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lpd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lpd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [lpd_pkg::LENGTH_W-1:0]        o_max_length
);

    logic [lpd_pkg::LENGTH_W-1:0] r_max_length;
    logic                         w_sel_max;

    // Word address bit picks the register; only index zero exists.
    assign w_sel_max = (paddr[2] == lpd_pkg::REG_MAX_LENGTH);

    // Register write on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= lpd_pkg::MAX_LENGTH_RST;
        end else if (psel && penable && pwrite && w_sel_max) begin
            r_max_length <= pwdata;
        end
    end

    // Read data; an address beyond the register reads as zero.
    always_comb begin
        prdata = '0;
        if (w_sel_max) begin
            prdata = r_max_length;
        end
    end

    assign pready       = 1'b1;
    assign o_max_length = r_max_length;

endmodule

/* src/lpd_in_stage.sv */
// Input register that holds one received byte for the deframing core.
`timescale 1ns / 1ps
module lpd_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [lpd_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                        o_in_ready,
    input  logic                        i_take,
    output lpd_pkg::t_in_req            o_req
);

    logic                       r_valid;
    logic [lpd_pkg::BYTE_W-1:0] r_byte;
    logic                       w_ready;

    // The register is free when empty or when the core takes its byte now.
    assign w_ready = !r_valid || i_take;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // Payload byte needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_ready && i_in_valid) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_in_ready    = w_ready;
    assign o_req.valid   = r_valid;
    assign o_req.rx_byte = r_byte;

endmodule

/* src/lpd_core.sv */
// Deframing state and result register: header gathering and payload counting.
`timescale 1ns / 1ps
module lpd_core #(
    parameter int LENGTH_BYTES = lpd_pkg::LENGTH_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpd_pkg::t_in_req              i_req,
    output logic                          o_take,
    input  logic [lpd_pkg::LENGTH_W-1:0]  i_max_length,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_kind,
    output logic [lpd_pkg::BYTE_W-1:0]    o_data_byte,
    output logic                          o_last,
    output logic [lpd_pkg::LENGTH_W-1:0]  o_packet_length
);

    localparam logic [lpd_pkg::HCOUNT_W:0] HDR_BYTES = (lpd_pkg::HCOUNT_W+1)'(LENGTH_BYTES);

    // Deframing state.
    logic                            r_in_payload,    n_in_payload;
    logic [lpd_pkg::HCOUNT_W-1:0]    r_header_count,  n_header_count;
    logic [lpd_pkg::LENGTH_W-1:0]    r_length_gather, n_length_gather;
    logic [lpd_pkg::LENGTH_W-1:0]    r_total_length,  n_total_length;
    logic [lpd_pkg::LENGTH_W-1:0]    r_remaining,     n_remaining;

    // Result register.
    logic                            r_out_valid,     n_out_valid;
    lpd_pkg::t_kind                  r_kind,          n_kind;
    logic [lpd_pkg::BYTE_W-1:0]      r_data_byte,     n_data_byte;
    logic                            r_last,          n_last;
    logic [lpd_pkg::LENGTH_W-1:0]    r_packet_length, n_packet_length;

    logic                            w_take;
    logic                            w_produce;
    logic [lpd_pkg::LENGTH_W-1:0]    w_len;
    logic                            w_header_done;

    // A byte is taken whenever the result register can be refilled.
    assign w_take = i_req.valid && (!r_out_valid || i_out_ready);

    // Length so far with the new byte placed at its byte lane.
    assign w_len = r_length_gather
                 | (lpd_pkg::LENGTH_W'(i_req.rx_byte) << {r_header_count, 3'b000});
    assign w_header_done = ({1'b0, r_header_count} + 1'b1) >= HDR_BYTES;

    // Next state and result for the byte being taken.
    always_comb begin
        n_in_payload    = r_in_payload;
        n_header_count  = r_header_count;
        n_length_gather = r_length_gather;
        n_total_length  = r_total_length;
        n_remaining     = r_remaining;
        n_kind          = r_kind;
        n_data_byte     = r_data_byte;
        n_last          = r_last;
        n_packet_length = r_packet_length;
        w_produce       = 1'b0;

        if (r_in_payload) begin
            w_produce   = 1'b1;
            n_kind      = lpd_pkg::KIND_PAYLOAD;
            n_data_byte = i_req.rx_byte;
            if (r_remaining <= lpd_pkg::LENGTH_W'(1)) begin
                // Final payload byte closes the packet.
                n_last          = 1'b1;
                n_packet_length = r_total_length;
                n_in_payload    = 1'b0;
                n_total_length  = '0;
                n_remaining     = '0;
            end else begin
                n_last          = 1'b0;
                n_remaining     = r_remaining - 1'b1;
                n_packet_length = r_remaining - 1'b1;
            end
        end else if (!w_header_done) begin
            // Partial header: keep gathering, no result.
            n_length_gather = w_len;
            n_header_count  = r_header_count + 1'b1;
        end else begin
            // Complete header: judge the length.
            w_produce       = 1'b1;
            n_header_count  = '0;
            n_length_gather = '0;
            n_data_byte     = '0;
            n_packet_length = w_len;
            if (w_len > i_max_length) begin
                n_kind = lpd_pkg::KIND_REJECT;
                n_last = 1'b0;
            end else if (w_len == '0) begin
                n_kind = lpd_pkg::KIND_EMPTY;
                n_last = 1'b1;
            end else begin
                n_kind         = lpd_pkg::KIND_HEADER;
                n_last         = 1'b0;
                n_total_length = w_len;
                n_remaining    = w_len;
                n_in_payload   = 1'b1;
            end
        end
    end

    // Output valid follows the taken byte or drains on acceptance.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = w_produce;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload    <= 1'b0;
            r_header_count  <= '0;
            r_length_gather <= '0;
            r_total_length  <= '0;
            r_remaining     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_take) begin
                r_in_payload    <= n_in_payload;
                r_header_count  <= n_header_count;
                r_length_gather <= n_length_gather;
                r_total_length  <= n_total_length;
                r_remaining     <= n_remaining;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_take && w_produce) begin
            r_kind          <= n_kind;
            r_data_byte     <= n_data_byte;
            r_last          <= n_last;
            r_packet_length <= n_packet_length;
        end
    end

    assign o_take          = w_take;
    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_data_byte     = r_data_byte;
    assign o_last          = r_last;
    assign o_packet_length = r_packet_length;

endmodule

/* src/length_prefix_deframer_unit.sv */
// A request accepted by the input register has its result shown by the result register
// (input register, then result register); partial header bytes give none.
// Throughput: one byte per cycle while results are accepted, set by the single-pass deframing core.
// Reset: synchronous, active low; clears phase, counters and output valid,
// and sets the largest accepted length to all ones.
`timescale 1ns / 1ps
module length_prefix_deframer_unit #(
    parameter int LENGTH_BYTES = lpd_pkg::LENGTH_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lpd_pkg::BYTE_W-1:0]        i_rx_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_kind,
    output logic [lpd_pkg::BYTE_W-1:0]        o_data_byte,
    output logic                              o_last,
    output logic [lpd_pkg::LENGTH_W-1:0]      o_packet_length,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lpd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lpd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [lpd_pkg::LENGTH_W-1:0] w_max_length;
    lpd_pkg::t_in_req             w_req;
    logic                         w_take;

    // Configuration register.
    lpd_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_max_length (w_max_length)
    );

    // Input register.
    lpd_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .o_in_ready (o_in_ready),
        .i_take     (w_take),
        .o_req      (w_req)
    );

    // Deframing core and result register.
    lpd_core #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (w_req),
        .o_take          (w_take),
        .i_max_length    (w_max_length),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_last          (o_last),
        .o_packet_length (o_packet_length)
    );

endmodule

/* src/lpd_checker.sv */
// Port-level checks on the deframer's result channel, bound to the top level.
`timescale 1ns / 1ps
module lpd_assert_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [1:0]                    o_kind,
    input logic [lpd_pkg::BYTE_W-1:0]    o_data_byte,
    input logic                          o_last,
    input logic [lpd_pkg::LENGTH_W-1:0]  o_packet_length
);

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_data_byte)
            && $stable(o_last) && $stable(o_packet_length))
        else $error("stalled result changed");

    // Only payload results carry a data byte.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != lpd_pkg::KIND_PAYLOAD) |-> (o_data_byte == '0))
        else $error("data byte on a non-payload result");

    // An empty packet is last and of length zero.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == lpd_pkg::KIND_EMPTY) |->
            o_last && (o_packet_length == '0))
        else $error("malformed empty packet result");

    // Header and reject results never close a packet.
    a_no_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_kind == lpd_pkg::KIND_HEADER)
            || (o_kind == lpd_pkg::KIND_REJECT)) |-> !o_last)
        else $error("last flag on header or reject result");

endmodule

bind length_prefix_deframer_unit lpd_assert_checker u_lpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_kind          (o_kind),
    .o_data_byte     (o_data_byte),
    .o_last          (o_last),
    .o_packet_length (o_packet_length)
);

/* sim/lpd_checker.sv */
// Checker for the length-prefix deframer: predicts every result and compares it.
`timescale 1ns / 1ps
module lpd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [lpd_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [1:0]                     i_kind,
    input  logic [lpd_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                           i_last,
    input  logic [lpd_pkg::LENGTH_W-1:0]   i_packet_length,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [lpd_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [lpd_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                             o_fail_count,
    output int                             o_pending
);

    // One result as the block presents it.
    typedef struct packed {
        lpd_pkg::t_kind               kind;
        logic [lpd_pkg::BYTE_W-1:0]   data_byte;
        logic                         last;
        logic [lpd_pkg::LENGTH_W-1:0] packet_length;
    } t_frame_result;

    t_frame_result expected_results[$];

    // Own copy of the deframing state and of the length limit.
    logic                         in_payload_q;
    logic [lpd_pkg::HCOUNT_W-1:0] hdr_count;
    logic [lpd_pkg::LENGTH_W-1:0] len_gather;
    logic [lpd_pkg::LENGTH_W-1:0] pkt_length;
    logic [lpd_pkg::LENGTH_W-1:0] bytes_left;
    logic [lpd_pkg::LENGTH_W-1:0] max_len;
    int                           fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    // Advance the deframing state by one received byte and queue any result.
    task automatic deframe_byte(input logic [lpd_pkg::BYTE_W-1:0] b);
        t_frame_result                res;
        logic [lpd_pkg::LENGTH_W-1:0] len;
        if (in_payload_q) begin
            if (bytes_left <= 1) begin
                res = '{lpd_pkg::KIND_PAYLOAD, b, 1'b1, pkt_length};
                in_payload_q = 1'b0;
                pkt_length   = '0;
                bytes_left   = '0;
            end else begin
                bytes_left = bytes_left - 1;
                res = '{lpd_pkg::KIND_PAYLOAD, b, 1'b0, bytes_left};
            end
            expected_results.push_back(res);
        end else begin
            len = len_gather | (lpd_pkg::LENGTH_W'(b) << (8 * hdr_count));
            if (int'(hdr_count) + 1 < lpd_pkg::LENGTH_BYTES_DEF) begin
                // A partial header is kept and gives no result.
                len_gather = len;
                hdr_count  = hdr_count + 1'b1;
            end else begin
                hdr_count  = '0;
                len_gather = '0;
                if (len > max_len) begin
                    res = '{lpd_pkg::KIND_REJECT, '0, 1'b0, len};
                end else if (len == '0) begin
                    res = '{lpd_pkg::KIND_EMPTY, '0, 1'b1, '0};
                end else begin
                    pkt_length   = len;
                    bytes_left   = len;
                    in_payload_q = 1'b1;
                    res = '{lpd_pkg::KIND_HEADER, '0, 1'b0, len};
                end
                expected_results.push_back(res);
            end
        end
    endtask

    // Follow register writes and both channels at every rising edge.
    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            in_payload_q = 1'b0;
            hdr_count    = '0;
            len_gather   = '0;
            pkt_length   = '0;
            bytes_left   = '0;
            max_len      = lpd_pkg::MAX_LENGTH_RST;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr[2] == lpd_pkg::REG_MAX_LENGTH) begin
                max_len = i_pwdata;
            end
            // The result side is checked first, so a request accepted at the same
            // edge can never be matched against its own result.
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("Unexpected result: kind %0d length %0d", i_kind, i_packet_length);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (lpd_pkg::t_kind'(i_kind) != want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, i_kind);
                        fail_count++;
                    end
                    if (i_data_byte != want.data_byte) begin
                        $error("data_byte: expected 0x%02h, got 0x%02h",
                               want.data_byte, i_data_byte);
                        fail_count++;
                    end
                    if (i_last != want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_last);
                        fail_count++;
                    end
                    if (i_packet_length != want.packet_length) begin
                        $error("packet_length: expected %0d, got %0d",
                               want.packet_length, i_packet_length);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                deframe_byte(i_rx_byte);
            end
        end
    end

endmodule

/* sim/length_prefix_deframer_unit_test.sv */
// Top of the deframer test: drives bytes and register writes, and reports the verdict.
`timescale 1ns / 1ps
module length_prefix_deframer_unit_test;

    localparam logic [lpd_pkg::APB_ADDR_W-1:0] ADDR_MAX_LENGTH = 3'd0;
    localparam logic [lpd_pkg::APB_ADDR_W-1:0] ADDR_UNUSED     = 3'd4;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int BYTES_PER_SET = 145;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [lpd_pkg::BYTE_W-1:0]     i_rx_byte = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [1:0]                     o_kind;
    logic [lpd_pkg::BYTE_W-1:0]     o_data_byte;
    logic                           o_last;
    logic [lpd_pkg::LENGTH_W-1:0]   o_packet_length;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [lpd_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [lpd_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [lpd_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    int                             fail_count;
    int                             pending;
    int                             send_idle_pct = 0;
    int                             recv_stall_pct = 0;
    int                             bytes_sent = 0;
    int                             quiet_cycles = 0;
    logic [lpd_pkg::LENGTH_W-1:0]   max_now = lpd_pkg::MAX_LENGTH_RST;

    length_prefix_deframer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_last          (o_last),
        .o_packet_length (o_packet_length),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    lpd_checker frame_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_kind          (o_kind),
        .i_data_byte     (o_data_byte),
        .i_last          (o_last),
        .i_packet_length (o_packet_length),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Free-running 100 MHz clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random, at the rate the current phase asks for.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run if neither channel nor the register port moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte, after any random idle cycles, and hold it until accepted.
    task automatic send_byte(input logic [lpd_pkg::BYTE_W-1:0] b);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        bytes_sent++;
    endtask

    // Send a little-endian length header, then the payload if it will be accepted.
    task automatic send_frame(input logic [lpd_pkg::LENGTH_W-1:0] len);
        for (int i = 0; i < lpd_pkg::LENGTH_BYTES_DEF; i++) begin
            send_byte(len[8*i +: 8]);
        end
        if (len != '0 && len <= max_now) begin
            for (int unsigned i = 0; i < len; i++) begin
                send_byte(lpd_pkg::BYTE_W'($urandom));
            end
        end
    endtask

    // Pick a frame length: mostly short accepted packets, with empty, rejected
    // and wholly random lengths mixed in.
    function automatic logic [lpd_pkg::LENGTH_W-1:0] choose_length(
        input logic [lpd_pkg::LENGTH_W-1:0] lim);
        int                           pick;
        logic [lpd_pkg::LENGTH_W-1:0] cap;
        pick = $urandom_range(99);
        cap  = (lim < 48) ? lim : 48;
        if ($urandom_range(99) < 3) begin
            cap = (lim < 300) ? lim : 300;
        end
        if (pick < 8 || lim == '0 && pick >= 25) begin
            return '0;
        end else if (pick < 25 && lim != '1) begin
            return $urandom_range(32'hFFFF_FFFF, lim + 1);
        end else if (pick < 32 && lim <= 64) begin
            return $urandom;
        end else if (lim == '0) begin
            return '0;
        end
        return $urandom_range(cap, 1);
    endfunction

    // Register write: a setup phase, then an access phase held until pready.
    task automatic reg_write(input logic [lpd_pkg::APB_ADDR_W-1:0] addr,
                             input logic [lpd_pkg::APB_DATA_W-1:0] data);
        logic done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == lpd_pkg::REG_MAX_LENGTH) begin
            max_now = data;
        end
    endtask

    // Stop offering bytes and wait until every result is in and the pipe is empty.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus: reset, a directed opening, then random frames in three idling phases.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset limit of all ones: empty packet, then one- and two-byte packets.
        send_frame(32'd0);
        send_frame(32'd1);
        // A write to an unmapped address must leave the limit alone.
        wait_drained();
        reg_write(ADDR_UNUSED, 32'd0);
        send_frame(32'd2);
        // Limit of zero: the largest length and a length of one are both rejected.
        wait_drained();
        reg_write(ADDR_MAX_LENGTH, 32'd0);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'd1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 68;
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 23;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int set = 0; set < 4; set++) begin
                wait_drained();
                case (set)
                    0:       reg_write(ADDR_MAX_LENGTH, lpd_pkg::MAX_LENGTH_RST);
                    1:       reg_write(ADDR_MAX_LENGTH, 32'd0);
                    2:       reg_write(ADDR_MAX_LENGTH, $urandom_range(64, 1));
                    default: reg_write(ADDR_MAX_LENGTH, $urandom);
                endcase
                bytes_sent = 0;
                while (bytes_sent < BYTES_PER_SET) begin
                    send_frame(choose_length(max_now));
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* length_prefix_deframer_unit.f */
src/lpd_pkg.sv
src/lpd_regs.sv
src/lpd_in_stage.sv
src/lpd_core.sv
src/length_prefix_deframer_unit.sv
src/lpd_checker.sv
sim/lpd_checker.sv
sim/length_prefix_deframer_unit_test.sv
